// ===== hdl/gbpf_pkg.sv =====
package gbpf_pkg;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [2:0] CFG_GRID_HEIGHT     = 3'd0;
	localparam logic [2:0] CFG_GRID_WIDTH      = 3'd1;
	localparam logic [2:0] CFG_REGION_ROW_LOW  = 3'd2;
	localparam logic [2:0] CFG_REGION_ROW_HIGH = 3'd3;
	localparam logic [2:0] CFG_REGION_COL_LOW  = 3'd4;
	localparam logic [2:0] CFG_REGION_COL_HIGH = 3'd5;

	localparam logic [5:0] RST_GRID_HEIGHT     = 6'd32;
	localparam logic [5:0] RST_GRID_WIDTH      = 6'd32;
	localparam logic [4:0] RST_REGION_ROW_LOW  = 5'd3;
	localparam logic [5:0] RST_REGION_ROW_HIGH = 6'd15;
	localparam logic [4:0] RST_REGION_COL_LOW  = 5'd4;
	localparam logic [5:0] RST_REGION_COL_HIGH = 6'd23;

	localparam logic [10:0] PATH_LEN_MAX = 11'd2047;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_SEARCH,
		CMD_READ,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [4:0] row;
		logic [4:0] col;
		logic       wall;
		logic       region;
		logic [4:0] goal_row;
		logic [4:0] goal_col;
		logic [9:0] path_index;
	} cmd_t;

	typedef struct packed {
		logic [5:0] grid_height;
		logic [5:0] grid_width;
		logic [4:0] row_low;
		logic [5:0] row_high;
		logic [4:0] col_low;
		logic [5:0] col_high;
	} cfg_t;

endpackage

// ===== hdl/gbpf_front.sv =====
module gbpf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [4:0]        cell_row,
	input  logic [4:0]        cell_col,
	input  logic              wall_flag,
	input  logic              region_flag,
	input  logic [4:0]        goal_row,
	input  logic [4:0]        goal_col,
	input  logic [9:0]        path_index,
	output logic              cmd_valid,
	input  logic              cmd_stall,
	output gbpf_pkg::cmd_t    cmd
);

	gbpf_pkg::cmd_t slot_q [2];
	gbpf_pkg::cmd_t new_cmd;
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	always_comb begin
		new_cmd.row        = cell_row;
		new_cmd.col        = cell_col;
		new_cmd.wall       = wall_flag;
		new_cmd.region     = region_flag;
		new_cmd.goal_row   = goal_row;
		new_cmd.goal_col   = goal_col;
		new_cmd.path_index = path_index;
		case (req_type)
			gbpf_pkg::REQ_LOAD:   new_cmd.kind = gbpf_pkg::CMD_LOAD;
			gbpf_pkg::REQ_SEARCH: new_cmd.kind = gbpf_pkg::CMD_SEARCH;
			gbpf_pkg::REQ_READ:   new_cmd.kind = gbpf_pkg::CMD_READ;
			default:              new_cmd.kind = gbpf_pkg::CMD_NOP;
		endcase
	end

	assign in_stall  = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = in_valid && !in_stall;
	assign pop       = cmd_valid && !cmd_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/gbpf_back.sv =====
module gbpf_back #(
	parameter int GRID_ROWS = 32,
	parameter int GRID_COLS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gbpf_pkg::cfg_t    cfg,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  gbpf_pkg::cmd_t    cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [10:0]       path_length,
	output logic [4:0]        out_row,
	output logic [4:0]        out_col,
	output logic              entry_valid
);

	localparam int RW         = $clog2(GRID_ROWS);
	localparam int CW         = $clog2(GRID_COLS);
	localparam int AW         = RW + CW;
	localparam int NCELLS     = GRID_ROWS * GRID_COLS;
	localparam int CELL_DEPTH = 1 << AW;
	localparam int QAW        = $clog2(NCELLS + 1);
	localparam int QCW        = $clog2(NCELLS + 2);
	localparam int BAW        = $clog2(NCELLS);
	localparam int DCW        = $clog2(NCELLS + 1);
	localparam int PW         = $clog2(NCELLS + 1);
	localparam int LW         = $clog2(NCELLS + 2);

	localparam logic [6:0] ROWS_LIM = 7'(GRID_ROWS);
	localparam logic [6:0] COLS_LIM = 7'(GRID_COLS);

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_EAST  = 2'd1;
	localparam logic [1:0] DIR_SOUTH = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_WAIT,
		S_CLEAR,
		S_POP,
		S_CUR,
		S_WALL,
		S_NB_RD,
		S_NB_CHK,
		S_TR_RD,
		S_TR_DATA,
		S_COPY_RD,
		S_COPY_WR
	} state_t;

	// Cell flags: bit 1 is the wall, bit 0 the region flag.
	logic [1:0]    cell_mem [CELL_DEPTH];
	// Search marks: top bit visited, the rest the parent cell.
	logic [AW:0]   vis_mem  [CELL_DEPTH];
	logic [AW-1:0] q_mem    [NCELLS + 1];
	logic [AW-1:0] bw_mem   [NCELLS];
	logic [9:0]    ps_mem   [NCELLS + 1];

	state_t          state_q;
	logic            out_valid_q;
	logic [4:0]      out_row_q;
	logic [4:0]      out_col_q;
	logic            entry_valid_q;
	logic            rd_hit_q;
	logic [LW-1:0]   stored_len_q;
	logic [AW-1:0]   start_q;
	logic [AW-1:0]   goal_q;
	logic [AW-1:0]   cur_q;
	logic [AW-1:0]   nb_q;
	logic [AW-1:0]   tr_cur_q;
	logic [AW-1:0]   clr_q;
	logic [1:0]      dir_q;
	logic [QCW-1:0]  head_q;
	logic [QCW-1:0]  tail_q;
	logic [DCW-1:0]  depth_q;
	logic [DCW-1:0]  cp_q;

	logic [1:0]      cell_rdata;
	logic [AW:0]     vis_rdata;
	logic [AW-1:0]   q_rdata;
	logic [AW-1:0]   bw_rdata;
	logic [9:0]      ps_rdata;

	logic            cell_we;
	logic [AW-1:0]   cell_waddr;
	logic [AW-1:0]   cell_raddr;
	logic            vis_we;
	logic [AW-1:0]   vis_waddr;
	logic [AW:0]     vis_wdata;
	logic [AW-1:0]   vis_raddr;
	logic            q_we;
	logic [QAW-1:0]  q_waddr;
	logic [AW-1:0]   q_wdata;
	logic            bw_we;
	logic [BAW-1:0]  bw_raddr;
	logic [DCW-1:0]  bw_rpos;
	logic            ps_we;
	logic [PW-1:0]   ps_waddr;
	logic [9:0]      ps_wdata;
	logic [PW-1:0]   ps_raddr;

	logic            out_free;
	logic            take;
	logic [6:0]      eff_h;
	logic [6:0]      eff_w;
	logic            cmd_in_grid;
	logic            search_ok;
	logic [AW-1:0]   cmd_addr;
	logic [AW-1:0]   cmd_goal_addr;
	logic [RW-1:0]   cur_r;
	logic [CW-1:0]   cur_c;
	logic [RW:0]     nb_r;
	logic [CW:0]     nb_c;
	logic            nb_ok;
	logic [AW-1:0]   nb_addr;
	logic [RW-1:0]   chk_r;
	logic [CW-1:0]   chk_c;
	logic            accept;
	logic [AW-1:0]   tr_parent;
	logic [AW-1:0]   tr_next;

	assign out_free  = !out_valid_q || !out_stall;
	assign cmd_stall = !((state_q == S_IDLE) && out_free);
	assign take      = cmd_valid && !cmd_stall;

	assign eff_h = ({1'b0, cfg.grid_height} > ROWS_LIM) ? ROWS_LIM : {1'b0, cfg.grid_height};
	assign eff_w = ({1'b0, cfg.grid_width} > COLS_LIM) ? COLS_LIM : {1'b0, cfg.grid_width};

	assign cmd_in_grid   = ({2'b00, cmd.row} < ROWS_LIM) && ({2'b00, cmd.col} < COLS_LIM);
	assign search_ok     = ({2'b00, cmd.row} < eff_h) && ({2'b00, cmd.col} < eff_w) &&
	                       ({2'b00, cmd.goal_row} < eff_h) && ({2'b00, cmd.goal_col} < eff_w);
	assign cmd_addr      = {RW'(cmd.row), CW'(cmd.col)};
	assign cmd_goal_addr = {RW'(cmd.goal_row), CW'(cmd.goal_col)};

	assign cur_r = cur_q[AW-1:CW];
	assign cur_c = cur_q[CW-1:0];

	always_comb begin
		nb_r  = {1'b0, cur_r};
		nb_c  = {1'b0, cur_c};
		nb_ok = 1'b1;
		case (dir_q)
			DIR_NORTH: begin
				nb_ok = (cur_r != '0);
				nb_r  = {1'b0, cur_r} - (RW + 1)'(1);
			end
			DIR_EAST:  nb_c = {1'b0, cur_c} + (CW + 1)'(1);
			DIR_SOUTH: nb_r = {1'b0, cur_r} + (RW + 1)'(1);
			DIR_WEST: begin
				nb_ok = (cur_c != '0);
				nb_c  = {1'b0, cur_c} - (CW + 1)'(1);
			end
			default: nb_ok = 1'b0;
		endcase
		nb_ok   = nb_ok && (7'(nb_r) < eff_h) && (7'(nb_c) < eff_w);
		nb_addr = {nb_r[RW-1:0], nb_c[CW-1:0]};
	end

	assign chk_r  = nb_q[AW-1:CW];
	assign chk_c  = nb_q[CW-1:0];
	assign accept = !vis_rdata[AW] && cell_rdata[0] && !cell_rdata[1] &&
	                (7'(chk_r) > {2'b00, cfg.row_low}) && (7'(chk_r) < {1'b0, cfg.row_high}) &&
	                (7'(chk_c) > {2'b00, cfg.col_low}) && (7'(chk_c) < {1'b0, cfg.col_high});

	// A cell never reached in this search still has the goal as its parent.
	assign tr_parent = vis_rdata[AW] ? vis_rdata[AW-1:0] : goal_q;
	assign tr_next   = (tr_parent == tr_cur_q) ? start_q : tr_parent;

	assign bw_rpos  = depth_q - DCW'(1) - cp_q;
	assign bw_raddr = bw_rpos[BAW-1:0];

	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = cmd_addr;
		cell_raddr = q_rdata;
		vis_we     = 1'b0;
		vis_waddr  = nb_q;
		vis_wdata  = {1'b1, cur_q};
		vis_raddr  = nb_addr;
		q_we       = 1'b0;
		q_waddr    = tail_q[QAW-1:0];
		q_wdata    = nb_q;
		bw_we      = 1'b0;
		ps_we      = 1'b0;
		ps_waddr   = cp_q + PW'(1);
		ps_wdata   = bw_rdata[9:0];
		ps_raddr   = PW'(cmd.path_index);
		case (state_q)
			S_IDLE: begin
				if (take && cmd.kind == gbpf_pkg::CMD_LOAD && cmd_in_grid) begin
					cell_we = 1'b1;
				end
				if (take && cmd.kind == gbpf_pkg::CMD_SEARCH) begin
					ps_we    = 1'b1;
					ps_waddr = '0;
					ps_wdata = {cmd.row, cmd.col};
					// The start cell opens an empty queue at its first slot.
					q_we     = search_ok;
					q_waddr  = '0;
					q_wdata  = cmd_addr;
				end
			end
			S_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = '0;
			end
			S_NB_RD: cell_raddr = nb_addr;
			S_NB_CHK: begin
				vis_we = accept;
				q_we   = accept;
			end
			S_TR_RD: vis_raddr = tr_cur_q;
			S_TR_DATA: bw_we = 1'b1;
			S_COPY_WR: begin
				ps_we    = 1'b1;
				ps_wdata = {5'(bw_rdata[AW-1:CW]), 5'(bw_rdata[CW-1:0])};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_waddr] <= {cmd.wall, cmd.region};
		end
		cell_rdata <= cell_mem[cell_raddr];
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		vis_rdata <= vis_mem[vis_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= q_wdata;
		end
		q_rdata <= q_mem[head_q[QAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (bw_we) begin
			bw_mem[depth_q[BAW-1:0]] <= tr_cur_q;
		end
		bw_rdata <= bw_mem[bw_raddr];
	end

	always_ff @(posedge clk) begin
		if (ps_we) begin
			ps_mem[ps_waddr] <= ps_wdata;
		end
		ps_rdata <= ps_mem[ps_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			out_row_q     <= '0;
			out_col_q     <= '0;
			entry_valid_q <= 1'b0;
			rd_hit_q      <= 1'b0;
			stored_len_q  <= '0;
			start_q       <= '0;
			goal_q        <= '0;
			cur_q         <= '0;
			nb_q          <= '0;
			tr_cur_q      <= '0;
			clr_q         <= '0;
			dir_q         <= DIR_NORTH;
			head_q        <= '0;
			tail_q        <= '0;
			depth_q       <= '0;
			cp_q          <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (cmd.kind)
							gbpf_pkg::CMD_READ: begin
								rd_hit_q <= ({22'd0, cmd.path_index} < 32'(stored_len_q));
								state_q  <= S_RD_WAIT;
							end
							gbpf_pkg::CMD_SEARCH: begin
								stored_len_q <= LW'(1);
								start_q      <= cmd_addr;
								goal_q       <= cmd_goal_addr;
								if (search_ok) begin
									head_q  <= '0;
									tail_q  <= QCW'(1);
									clr_q   <= '0;
									state_q <= S_CLEAR;
								end else begin
									out_valid_q   <= 1'b1;
									out_row_q     <= '0;
									out_col_q     <= '0;
									entry_valid_q <= 1'b0;
								end
							end
							default: begin
								out_valid_q   <= 1'b1;
								out_row_q     <= '0;
								out_col_q     <= '0;
								entry_valid_q <= 1'b0;
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					out_valid_q   <= 1'b1;
					out_row_q     <= rd_hit_q ? ps_rdata[9:5] : 5'd0;
					out_col_q     <= rd_hit_q ? ps_rdata[4:0] : 5'd0;
					entry_valid_q <= rd_hit_q;
					state_q       <= S_IDLE;
				end
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (head_q == tail_q) begin
						tr_cur_q <= goal_q;
						depth_q  <= '0;
						state_q  <= S_TR_RD;
					end else begin
						head_q  <= head_q + QCW'(1);
						state_q <= S_CUR;
					end
				end
				S_CUR: begin
					cur_q   <= q_rdata;
					state_q <= S_WALL;
				end
				S_WALL: begin
					if (cell_rdata[1]) begin
						state_q <= S_POP;
					end else begin
						dir_q   <= DIR_NORTH;
						state_q <= S_NB_RD;
					end
				end
				S_NB_RD: begin
					if (nb_ok) begin
						nb_q    <= nb_addr;
						state_q <= S_NB_CHK;
					end else if (dir_q == DIR_WEST) begin
						state_q <= S_POP;
					end else begin
						dir_q <= dir_q + 2'd1;
					end
				end
				S_NB_CHK: begin
					if (accept) begin
						tail_q <= tail_q + QCW'(1);
					end
					if (dir_q == DIR_WEST) begin
						state_q <= S_POP;
					end else begin
						dir_q   <= dir_q + 2'd1;
						state_q <= S_NB_RD;
					end
				end
				S_TR_RD: begin
					if (tr_cur_q == start_q || depth_q == DCW'(NCELLS)) begin
						if (depth_q < DCW'(2)) begin
							out_valid_q   <= 1'b1;
							out_row_q     <= '0;
							out_col_q     <= '0;
							entry_valid_q <= 1'b0;
							state_q       <= S_IDLE;
						end else begin
							cp_q    <= '0;
							state_q <= S_COPY_RD;
						end
					end else begin
						state_q <= S_TR_DATA;
					end
				end
				S_TR_DATA: begin
					depth_q  <= depth_q + DCW'(1);
					tr_cur_q <= tr_next;
					state_q  <= S_TR_RD;
				end
				S_COPY_RD: state_q <= S_COPY_WR;
				S_COPY_WR: begin
					if (cp_q == depth_q - DCW'(1)) begin
						stored_len_q  <= LW'(depth_q) + LW'(1);
						out_valid_q   <= 1'b1;
						out_row_q     <= '0;
						out_col_q     <= '0;
						entry_valid_q <= 1'b0;
						state_q       <= S_IDLE;
					end else begin
						cp_q    <= cp_q + DCW'(1);
						state_q <= S_COPY_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign entry_valid = entry_valid_q;
	assign path_length = (32'(stored_len_q) > 32'(gbpf_pkg::PATH_LEN_MAX)) ?
	                     gbpf_pkg::PATH_LEN_MAX : 11'(stored_len_q);

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> cmd_stall)
		else $error("command taken while a search or read is in progress");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("search queue head passed its tail");

	a_trace_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TR_DATA) |-> (depth_q < DCW'(NCELLS)))
		else $error("path trace ran past the cell count");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_WAIT) |-> !out_valid_q)
		else $error("read result would overwrite a pending item");

endmodule

// ===== hdl/grid_bfs_path_finder.sv =====
// Loads and no-op items pass the item queue and the result register; back to back they go
// one per cycle while the output is not stalled. Path reads also read the path store and
// hold off the next item until their result is registered. Searches: a clearing sweep of
// all 2^(row bits + column bits) mark addresses, a check of each direction and in-grid
// neighbor per dequeued cell, then path trace and copy; items wait until the search
// result is out. Reset (arst_n low, asynchronous) empties the item queue and result slot,
// sets the stored path length to zero and the bound registers to 32, 32, 3, 15, 4, 23.
module grid_bfs_path_finder #(
	parameter int GRID_ROWS = 32,
	parameter int GRID_COLS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [4:0]  cell_row,
	input  logic [4:0]  cell_col,
	input  logic        wall_flag,
	input  logic        region_flag,
	input  logic [4:0]  goal_row,
	input  logic [4:0]  goal_col,
	input  logic [9:0]  path_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] path_length,
	output logic [4:0]  out_row,
	output logic [4:0]  out_col,
	output logic        entry_valid
);

	gbpf_pkg::cfg_t cfg_q;
	gbpf_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_height <= gbpf_pkg::RST_GRID_HEIGHT;
			cfg_q.grid_width  <= gbpf_pkg::RST_GRID_WIDTH;
			cfg_q.row_low     <= gbpf_pkg::RST_REGION_ROW_LOW;
			cfg_q.row_high    <= gbpf_pkg::RST_REGION_ROW_HIGH;
			cfg_q.col_low     <= gbpf_pkg::RST_REGION_COL_LOW;
			cfg_q.col_high    <= gbpf_pkg::RST_REGION_COL_HIGH;
		end else if (cfg_we) begin
			case (cfg_index)
				gbpf_pkg::CFG_GRID_HEIGHT:     cfg_q.grid_height <= cfg_data;
				gbpf_pkg::CFG_GRID_WIDTH:      cfg_q.grid_width  <= cfg_data;
				gbpf_pkg::CFG_REGION_ROW_LOW:  cfg_q.row_low     <= cfg_data[4:0];
				gbpf_pkg::CFG_REGION_ROW_HIGH: cfg_q.row_high    <= cfg_data;
				gbpf_pkg::CFG_REGION_COL_LOW:  cfg_q.col_low     <= cfg_data[4:0];
				gbpf_pkg::CFG_REGION_COL_HIGH: cfg_q.col_high    <= cfg_data;
				default: ;
			endcase
		end
	end

	gbpf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.wall_flag   (wall_flag),
		.region_flag (region_flag),
		.goal_row    (goal_row),
		.goal_col    (goal_col),
		.path_index  (path_index),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd)
	);

	gbpf_back #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.path_length (path_length),
		.out_row     (out_row),
		.out_col     (out_col),
		.entry_valid (entry_valid)
	);

endmodule
